>>> rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cjm_pkg.sv
// types, constants and decode helpers of the card job machine
package cjm_pkg;

    localparam logic [31:0] SPACES = 32'h2020_2020;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_H = 8'h48;

    localparam logic [2:0] ACT_NEW    = 3'd0;
    localparam logic [2:0] ACT_LOAD   = 3'd1;
    localparam logic [2:0] ACT_START  = 3'd2;
    localparam logic [2:0] ACT_STEP   = 3'd3;
    localparam logic [2:0] ACT_CARD   = 3'd4;
    localparam logic [2:0] ACT_ABSENT = 3'd5;

    localparam logic [2:0] KIND_ACC   = 3'd0;
    localparam logic [2:0] KIND_OUTW  = 3'd1;
    localparam logic [2:0] KIND_CARD  = 3'd2;
    localparam logic [2:0] KIND_HALT  = 3'd3;
    localparam logic [2:0] KIND_FAULT = 3'd4;

    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_ADDR  = 3'd1;
    localparam logic [2:0] FLT_IC    = 3'd2;
    localparam logic [2:0] FLT_LOAD  = 3'd3;
    localparam logic [2:0] FLT_MODE  = 3'd4;

    localparam int DADDR_W = 7;

    typedef enum logic [2:0] {
        CMD_NEW, CMD_LOAD, CMD_START, CMD_STEP, CMD_CARD, CMD_ABSENT, CMD_BAD
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] word;
    } t_req;

    typedef enum logic [1:0] {
        MODE_IDLE, MODE_LOAD, MODE_RUN, MODE_WAIT
    } t_mode;

    typedef enum logic [2:0] {
        OP_LR, OP_SR, OP_CR, OP_BT, OP_GD, OP_PD, OP_H, OP_NOP
    } t_op;

    function automatic t_op dec_op(input logic [7:0] c0, input logic [7:0] c1);
        t_op op;
        op = OP_NOP;
        if (c0 == CH_L && c1 == CH_R) op = OP_LR;
        else if (c0 == CH_S && c1 == CH_R) op = OP_SR;
        else if (c0 == CH_C && c1 == CH_R) op = OP_CR;
        else if (c0 == CH_B && c1 == CH_T) op = OP_BT;
        else if (c0 == CH_G && c1 == CH_D) op = OP_GD;
        else if (c0 == CH_P && c1 == CH_D) op = OP_PD;
        else if (c0 == CH_H) op = OP_H;
        return op;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_ZERO + 8'd9);
    endfunction

endpackage

>>> rtl/card_job_machine_executor.sv
// top level of the card job machine executor
//
//  channel   dir   handshake           payload
//  request   in    i_valid / o_stall   i_action, i_word
//  result    out   o_valid / i_stall   o_kind, o_word_out, o_last, o_fault
//
//  a request other than a step passes the front register and the queue, and its result is registered
//  a step passes through issue read, decode and execute before its result is registered
//  a print step gives BLOCK_WORDS results, one a cycle while the result channel does not stall
//  card absent after a partial card fills each remaining word of the card with spaces, then gives its result
//  synchronous active-low reset; memory contents are undefined, written flags clear
//  a stalled result holds in the output register while up to three requests queue
module card_job_machine_executor import cjm_pkg::*; #(
    parameter int MEM_WORDS   = 100,
    parameter int BLOCK_WORDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [31:0] o_word_out,
    output logic        o_last,
    output logic [2:0]  o_fault
);

    logic q_full;
    logic push;
    t_req f_req;
    logic pop;
    logic q_nempty;
    t_req q_req;

    cjm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_word   (i_word),
        .o_stall  (o_stall),
        .i_q_full (q_full),
        .o_push   (push),
        .o_req    (f_req)
    );

    cjm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_req    (f_req),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_nempty (q_nempty),
        .o_req    (q_req)
    );

    cjm_back #(
        .MEM_WORDS   (MEM_WORDS),
        .BLOCK_WORDS (BLOCK_WORDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nempty   (q_nempty),
        .i_req      (q_req),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_kind     (o_kind),
        .o_word_out (o_word_out),
        .o_last     (o_last),
        .o_fault    (o_fault)
    );

endmodule

>>> rtl/cjm_front.sv
// front stage: takes requests and classifies the action
module cjm_front import cjm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_word,
    output logic        o_stall,
    input  logic        i_q_full,
    output logic        o_push,
    output t_req        o_req
);

    logic r_v;
    t_req r_req;
    t_cmd cls;
    logic accept;

    always_comb begin
        unique case (i_action)
            ACT_NEW:    cls = CMD_NEW;
            ACT_LOAD:   cls = CMD_LOAD;
            ACT_START:  cls = CMD_START;
            ACT_STEP:   cls = CMD_STEP;
            ACT_CARD:   cls = CMD_CARD;
            ACT_ABSENT: cls = CMD_ABSENT;
            default:    cls = CMD_BAD;
        endcase
    end

    assign o_stall = r_v && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_v && !i_q_full;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (o_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.cmd  <= cls;
            r_req.word <= i_word;
        end
    end

endmodule

>>> rtl/cjm_queue.sv
// two-entry request queue between front and back
module cjm_queue import cjm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output logic o_nempty,
    output t_req o_req
);

    `include "assert_macros.svh"

    t_req       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full   = r_cnt == 2'd2;
    assign o_nempty = r_cnt != 2'd0;
    assign o_req    = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wp] <= i_req;
    end

    `AST_IMP(a_q_ptrs, (r_cnt == 2'd0 || r_cnt == 2'd2), (r_wp == r_rp), "queue pointers disagree with count")

endmodule

>>> rtl/cjm_back.sv
// back end: job state, word memory and instruction execution
module cjm_back import cjm_pkg::*; #(
    parameter int MEM_WORDS   = 100,
    parameter int BLOCK_WORDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nempty,
    input  t_req        i_req,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [31:0] o_word_out,
    output logic        o_last,
    output logic [2:0]  o_fault
);

    `include "assert_macros.svh"

    localparam int AW = $clog2(MEM_WORDS);
    localparam int CW = $clog2(MEM_WORDS + 1);
    localparam int BW = $clog2(BLOCK_WORDS + 1);
    localparam int PW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_EXEC  = 5'b00100,
        S_PRINT = 5'b01000,
        S_FILL  = 5'b10000
    } t_state;

    logic [31:0]    mem [MEM_WORDS];
    logic           r_wr [MEM_WORDS];
    logic [31:0]    r_rd;
    logic           r_rdv;

    t_state         r_st, n_st;
    t_mode          r_mode, n_mode;
    logic [31:0]    r_gr, n_gr;
    logic           r_tog, n_tog;
    logic [CW-1:0]  r_ic, n_ic;
    logic [CW-1:0]  r_lp, n_lp;
    logic [AW-1:0]  r_cb, n_cb;
    logic [BW-1:0]  r_cc, n_cc;
    t_op            r_op, n_op;
    logic [AW-1:0]  r_addr, n_addr;
    logic           r_aok, n_aok;
    logic           r_bok, n_bok;
    logic [PW-1:0]  r_pi, n_pi;

    logic           r_ov;
    logic [2:0]     r_kind;
    logic [31:0]    r_wo;
    logic           r_last;
    logic [2:0]     r_flt;

    logic           out_free;
    logic           emit;
    logic [2:0]     e_kind;
    logic [31:0]    e_word;
    logic           e_last;
    logic [2:0]     e_flt;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [31:0]    mem_wd;
    logic [AW-1:0]  mem_ra;
    logic           wr_clr;
    logic [31:0]    rval;
    logic [7:0]     c0, c1, c2, c3;
    logic [DADDR_W-1:0] daddr;
    logic           d_aok;
    logic           d_bok;
    logic           op_addr;

    assign out_free = !r_ov || !i_stall;
    assign rval = r_rdv ? r_rd : SPACES;
    assign c0 = rval[31:24];
    assign c1 = rval[23:16];
    assign c2 = rval[15:8];
    assign c3 = rval[7:0];
    assign daddr = DADDR_W'(c2[3:0]) * DADDR_W'(10) + DADDR_W'(c3[3:0]);
    assign d_aok = is_digit(c2) && is_digit(c3) && (daddr < DADDR_W'(MEM_WORDS));
    assign d_bok = d_aok &&
        ({1'b0, daddr} + (DADDR_W + 1)'(BLOCK_WORDS) <= (DADDR_W + 1)'(MEM_WORDS));
    assign op_addr = (r_op != OP_H) && (r_op != OP_NOP);

    always_comb begin
        n_st = r_st;   n_mode = r_mode; n_gr = r_gr;   n_tog = r_tog;
        n_ic = r_ic;   n_lp = r_lp;     n_cb = r_cb;   n_cc = r_cc;
        n_op = r_op;   n_addr = r_addr; n_aok = r_aok; n_bok = r_bok;
        n_pi = r_pi;
        o_pop = 1'b0;
        emit = 1'b0;   e_kind = KIND_ACC; e_word = '0; e_last = 1'b0; e_flt = FLT_NONE;
        mem_we = 1'b0; mem_wa = '0; mem_wd = SPACES; mem_ra = '0; wr_clr = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (i_nempty && out_free) begin
                    o_pop = 1'b1;
                    emit = 1'b1;
                    unique case (i_req.cmd)
                        CMD_NEW: begin
                            wr_clr = 1'b1;
                            n_gr = SPACES; n_tog = 1'b0; n_ic = '0; n_lp = '0;
                            n_cb = '0; n_cc = '0; n_mode = MODE_LOAD;
                        end
                        CMD_LOAD: begin
                            if (r_mode != MODE_LOAD) begin
                                e_kind = KIND_FAULT; e_flt = FLT_MODE;
                            end else if (r_lp >= CW'(MEM_WORDS)) begin
                                e_kind = KIND_FAULT; e_flt = FLT_LOAD;
                            end else begin
                                mem_we = 1'b1; mem_wa = r_lp[AW-1:0]; mem_wd = i_req.word;
                                n_lp = r_lp + 1'b1;
                            end
                        end
                        CMD_START: begin
                            if (r_mode != MODE_LOAD) begin
                                e_kind = KIND_FAULT; e_flt = FLT_MODE;
                            end else begin
                                n_ic = '0; n_mode = MODE_RUN;
                            end
                        end
                        CMD_STEP: begin
                            if (r_mode != MODE_RUN) begin
                                e_kind = KIND_FAULT; e_flt = FLT_MODE;
                            end else if (r_ic >= CW'(MEM_WORDS)) begin
                                e_kind = KIND_FAULT; e_flt = FLT_IC; n_mode = MODE_IDLE;
                            end else begin
                                emit = 1'b0;
                                mem_ra = r_ic[AW-1:0];
                                n_ic = r_ic + 1'b1;
                                n_st = S_FETCH;
                            end
                        end
                        CMD_CARD: begin
                            if (r_mode != MODE_WAIT) begin
                                e_kind = KIND_FAULT; e_flt = FLT_MODE;
                            end else begin
                                mem_we = 1'b1; mem_wa = r_cb + AW'(r_cc); mem_wd = i_req.word;
                                n_cc = r_cc + 1'b1;
                                if (r_cc == BW'(BLOCK_WORDS - 1)) n_mode = MODE_RUN;
                                else e_kind = KIND_CARD;
                            end
                        end
                        CMD_ABSENT: begin
                            if (r_mode != MODE_WAIT) begin
                                e_kind = KIND_FAULT; e_flt = FLT_MODE;
                            end else if (r_cc != '0) begin
                                emit = 1'b0;
                                n_st = S_FILL;
                            end else begin
                                n_mode = MODE_RUN;
                            end
                        end
                        default: begin
                            e_kind = KIND_FAULT; e_flt = FLT_MODE;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_op = dec_op(c0, c1);
                n_addr = AW'(daddr);
                n_aok = d_aok;
                n_bok = d_bok;
                mem_ra = d_aok ? AW'(daddr) : '0;
                n_st = S_EXEC;
            end
            S_EXEC: begin
                mem_ra = r_addr;
                if (out_free) begin
                    emit = 1'b1;
                    n_st = S_IDLE;
                    if (op_addr && (!r_aok || ((r_op == OP_GD || r_op == OP_PD) && !r_bok))) begin
                        e_kind = KIND_FAULT; e_flt = FLT_ADDR; n_mode = MODE_IDLE;
                    end else begin
                        case (r_op)
                            OP_LR: n_gr = rval;
                            OP_SR: begin
                                mem_we = 1'b1; mem_wa = r_addr; mem_wd = r_gr;
                            end
                            OP_CR: n_tog = (r_gr == rval);
                            OP_BT: if (r_tog) n_ic = CW'(r_addr);
                            OP_GD: begin
                                n_cb = r_addr; n_cc = '0; n_mode = MODE_WAIT; e_kind = KIND_CARD;
                            end
                            OP_PD: begin
                                emit = 1'b0; n_pi = '0; n_st = S_PRINT;
                            end
                            OP_H: begin
                                e_kind = KIND_HALT; n_mode = MODE_IDLE;
                            end
                            default: e_kind = KIND_ACC;
                        endcase
                    end
                end
            end
            S_PRINT: begin
                mem_ra = r_addr + AW'(r_pi);
                if (out_free) begin
                    emit = 1'b1; e_kind = KIND_OUTW; e_word = rval;
                    if (r_pi == PW'(BLOCK_WORDS - 1)) begin
                        e_last = 1'b1;
                        n_st = S_IDLE;
                    end else begin
                        n_pi = r_pi + 1'b1;
                        mem_ra = r_addr + AW'(r_pi) + AW'(1);
                    end
                end
            end
            S_FILL: begin
                if (r_cc != BW'(BLOCK_WORDS)) begin
                    mem_we = 1'b1; mem_wa = r_cb + AW'(r_cc); mem_wd = SPACES;
                    n_cc = r_cc + 1'b1;
                end else if (out_free) begin
                    emit = 1'b1; n_mode = MODE_RUN; n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || wr_clr) begin
            for (int k = 0; k < MEM_WORDS; k++) r_wr[k] <= 1'b0;
            r_rdv <= 1'b0;
        end else begin
            if (mem_we) r_wr[mem_wa] <= 1'b1;
            r_rdv <= r_wr[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;  r_mode <= MODE_IDLE; r_gr <= SPACES; r_tog <= 1'b0;
            r_ic <= '0;      r_lp <= '0;          r_cb <= '0;     r_cc <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;    r_mode <= n_mode;    r_gr <= n_gr;   r_tog <= n_tog;
            r_ic <= n_ic;    r_lp <= n_lp;        r_cb <= n_cb;   r_cc <= n_cc;
            if (emit) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_addr <= n_addr; r_aok <= n_aok; r_bok <= n_bok; r_pi <= n_pi;
        if (emit) begin
            r_kind <= e_kind; r_wo <= e_word; r_last <= e_last; r_flt <= e_flt;
        end
    end

    assign o_valid    = r_ov;
    assign o_kind     = r_kind;
    assign o_word_out = r_wo;
    assign o_last     = r_last;
    assign o_fault    = r_flt;

    `AST_IMP(a_last_kind, (r_ov && r_last), (r_kind == KIND_OUTW), "last flag on a non-print result")
    `AST_IMP(a_print_run, (r_st == S_PRINT || r_st == S_FETCH), (r_mode == MODE_RUN), "executing outside run mode")
    `AST_NXT(a_fill_wait, (r_st == S_FILL && r_cc != BW'(BLOCK_WORDS)), (r_st == S_FILL), "fill left early")

endmodule
